@@ design/tte_pkg.sv @@
// Shared types and constants for the tap tempo estimator.
`default_nettype none
package tte_pkg;

    // 60 s * 1000 ms * 10 (tenths of BPM)
    localparam logic [19:0] TEMPO_NUM = 20'd600000;

    localparam int CFG_DW = 16;
    localparam int CFG_IW = 2;
    localparam int TEMPO_W = 14;
    localparam int HELD_W = 3;

    localparam logic [CFG_IW-1:0] CFG_GAP_TIMEOUT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TEMPO_FLOOR = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TEMPO_CEIL  = 2'd2;

    localparam logic [15:0]        GAP_TIMEOUT_RST = 16'd2000;
    localparam logic [TEMPO_W-1:0] TEMPO_FLOOR_RST = 14'd200;
    localparam logic [TEMPO_W-1:0] TEMPO_CEIL_RST  = 14'd9990;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage
`default_nettype wire

@@ design/tte_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module tte_div #(
    parameter int QW = 21
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [31:0]       i_dividend,
    input  wire logic [31:0]       i_divisor,
    output tte_pkg::t_div_status   o_status,
    output logic      [QW-1:0]     o_quotient
);

    localparam int IW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] r_iter;
    logic [31:0]   r_rem;
    logic [31:0]   r_dvs;
    // dividend bits shift out the top while quotient bits shift in below
    logic [QW-1:0] r_q;

    logic [32:0] w_sh;
    logic [32:0] w_sub;
    logic        w_ge;

    assign w_sh  = {r_rem, r_q[QW-1]};
    assign w_ge  = (w_sh >= {1'b0, r_dvs});
    assign w_sub = w_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_iter == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_iter == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient fits in QW bits, so the top bits start below the divisor
            r_rem  <= 32'(i_dividend >> QW);
            r_q    <= i_dividend[QW-1:0];
            r_dvs  <= i_divisor;
            r_iter <= IW'(QW - 1);
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_sub[31:0] : w_sh[31:0];
            r_q    <= {r_q[QW-2:0], w_ge};
            r_iter <= r_iter - 1'b1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_q;

endmodule
`default_nettype wire

@@ design/tap_tempo_estimator.sv @@
// Tap tempo estimator: tap history, sequencer and clamped tempo result.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  input   | i_in_valid / o_in_ready | i_tap_time_ms
//  output  | o_out_valid/i_out_ready | o_tempo_x10, o_tempo_valid, o_taps_held
//  config  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Each tap steps through APPEND, PREP, START, DIV when it divides, and FINISH;
// a new tap is accepted only back in IDLE. The divider produces one quotient
// bit per cycle; QW is the width of 600000 * (MAX_TAPS - 1). Taps with fewer
// than two held skip the divider. The result sits in an output register, so
// a stalled output only holds the next tap at its final step. Reset clears
// the tap count and loads the register defaults; the stamp store is not cleared.
`default_nettype none
module tap_tempo_estimator #(
    parameter int MAX_TAPS = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [31:0]                  i_tap_time_ms,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [tte_pkg::TEMPO_W-1:0]       o_tempo_x10,
    output logic                              o_tempo_valid,
    output logic [tte_pkg::HELD_W-1:0]        o_taps_held,
    input  wire logic                         i_cfg_we,
    input  wire logic [tte_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [tte_pkg::CFG_DW-1:0]   i_cfg_data
);

    localparam int NUM_MAX = 600000 * (MAX_TAPS - 1);
    localparam int QW      = $clog2(NUM_MAX + 1);
    localparam int CW      = $clog2(MAX_TAPS + 1);
    localparam int SW      = $clog2(MAX_TAPS);
    localparam int TW      = tte_pkg::TEMPO_W;
    localparam int HW      = tte_pkg::HELD_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_APPEND = 6'b000010,
        S_PREP   = 6'b000100,
        S_START  = 6'b001000,
        S_DIV    = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [15:0]    r_gap_to;
    logic [TW-1:0]  r_floor;
    logic [TW-1:0]  r_ceil;

    logic [31:0]    r_stamps [MAX_TAPS];
    logic [CW-1:0]  r_count;
    logic [31:0]    r_now;
    logic [31:0]    r_newest;
    logic [31:0]    r_span;
    logic [31:0]    r_num;
    logic           r_res_valid;

    logic           r_out_valid;
    logic [TW-1:0]  r_out_tempo;
    logic           r_out_tvalid;
    logic [CW-1:0]  r_out_count;

    logic [31:0]    w_gap;
    logic [CW-1:0]  w_base;
    logic           w_div_start;
    logic [31:0]    w_dividend;
    logic           w_out_free;
    logic [QW-1:0]  w_quo;
    logic [QW-1:0]  w_floored;
    logic [TW-1:0]  w_tempo;

    tte_pkg::t_div_status w_div_st;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_to <= tte_pkg::GAP_TIMEOUT_RST;
            r_floor  <= tte_pkg::TEMPO_FLOOR_RST;
            r_ceil   <= tte_pkg::TEMPO_CEIL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tte_pkg::CFG_GAP_TIMEOUT: r_gap_to <= i_cfg_data;
                tte_pkg::CFG_TEMPO_FLOOR: r_floor  <= i_cfg_data[TW-1:0];
                tte_pkg::CFG_TEMPO_CEIL:  r_ceil   <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_div_start = (r_state == S_START) && r_res_valid && (r_span != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_APPEND;
            S_APPEND: n_state = S_PREP;
            S_PREP:   n_state = S_START;
            S_START:  n_state = w_div_start ? S_DIV : S_FINISH;
            S_DIV:    if (w_div_st.done) n_state = S_FINISH;
            S_FINISH: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // ---------------- tap history ----------------
    assign w_gap  = r_now - r_newest;
    // a long gap drops the held taps before the new one goes in
    assign w_base = ((r_count != '0) && (w_gap > {16'b0, r_gap_to})) ? '0 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == S_APPEND) begin
            if (w_base == CW'(MAX_TAPS)) begin
                r_count <= w_base;
            end else begin
                r_count <= w_base + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_now <= i_tap_time_ms;
        end
        if (r_state == S_APPEND) begin
            r_newest <= r_now;
            if (w_base == CW'(MAX_TAPS)) begin
                for (int i = 1; i < MAX_TAPS; i++) begin
                    r_stamps[i-1] <= r_stamps[i];
                end
                r_stamps[MAX_TAPS-1] <= r_now;
            end else begin
                r_stamps[w_base[SW-1:0]] <= r_now;
            end
        end
        if (r_state == S_PREP) begin
            r_span      <= r_newest - r_stamps[0];
            r_num       <= 32'(tte_pkg::TEMPO_NUM) * 32'(r_count - 1'b1);
            r_res_valid <= (r_count >= CW'(2));
        end
    end

    // ---------------- division ----------------
    // round half up: (num + span/2) / span
    assign w_dividend = r_num + {1'b0, r_span[31:1]};

    tte_div #(
        .QW(QW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_span),
        .o_status   (w_div_st),
        .o_quotient (w_quo)
    );

    // floor first, then ceiling, so the ceiling wins; zero span means "fastest"
    assign w_floored = (w_quo < QW'(r_floor)) ? QW'(r_floor) : w_quo;
    assign w_tempo   = ((r_span == '0) || (w_floored > QW'(r_ceil))) ? r_ceil
                                                                     : w_floored[TW-1:0];

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FINISH) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FINISH) && w_out_free) begin
            r_out_tempo  <= r_res_valid ? w_tempo : '0;
            r_out_tvalid <= r_res_valid;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_tempo_x10   = r_out_tempo;
    assign o_tempo_valid = r_out_tvalid;
    // low bits only when the count is wider than the port
    assign o_taps_held   = HW'(r_out_count);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TAPS))
        else $error("tap count above MAX_TAPS");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_st.busy)
        else $error("divider busy while sequencer idle");

    a_no_tempo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tempo_valid) |-> (o_tempo_x10 == '0))
        else $error("tempo nonzero on an invalid result");

    a_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tempo_valid) |-> (o_tempo_x10 <= r_ceil))
        else $error("tempo above ceiling");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FINISH) && w_out_free) |=> o_out_valid)
        else $error("finished item not presented");
`endif

endmodule
`default_nettype wire

@@ verif/tte_checker.sv @@
// Tap tempo checker: watches the tap and tempo channels, predicts each result and compares.
module tte_checker #(
    parameter int MAX_TAPS = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [31:0]                  i_tap_time_ms,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [tte_pkg::TEMPO_W-1:0]  i_tempo_x10,
    input  wire logic                         i_tempo_valid,
    input  wire logic [tte_pkg::HELD_W-1:0]   i_taps_held,
    input  wire logic                         i_cfg_we,
    input  wire logic [tte_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [tte_pkg::CFG_DW-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import tte_pkg::*;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic               valid;
        logic [HELD_W-1:0]  held;
    } tempo_result_t;

    logic [31:0]        tap_hist [MAX_TAPS];
    int unsigned        held_taps;
    logic [15:0]        gap_limit;
    logic [TEMPO_W-1:0] floor_x10;
    logic [TEMPO_W-1:0] ceil_x10;
    tempo_result_t      tempo_q [$];
    int                 fail_total = 0;
    int                 checked_total = 0;
    int                 pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;

    task automatic report_failure(input string msg);
        $display("[%0t] tempo check: %s", $realtime, msg);
        fail_total++;
    endtask

    // Updates the tap history with one tap and returns the tempo it yields.
    function automatic tempo_result_t take_tap(input logic [31:0] now);
        tempo_result_t res;
        logic [31:0]   gap;
        logic [31:0]   span;
        logic [63:0]   quot;
        logic [31:0]   bpm;
        res = '0;
        if (held_taps > 0) begin
            gap = now - tap_hist[held_taps-1];
            if (gap > {16'd0, gap_limit})
                held_taps = 0;
        end
        if (held_taps >= MAX_TAPS) begin
            for (int k = 1; k < MAX_TAPS; k++)
                tap_hist[k-1] = tap_hist[k];
            tap_hist[MAX_TAPS-1] = now;
            held_taps = MAX_TAPS;
        end else begin
            tap_hist[held_taps] = now;
            held_taps++;
        end
        if (held_taps >= 2) begin
            span = tap_hist[held_taps-1] - tap_hist[0];
            // all taps on one stamp: treat as infinitely fast, ceiling clamps it
            if (span == 0)
                quot = 64'hFFFF_FFFF;
            else
                quot = (64'(TEMPO_NUM) * 64'(held_taps - 1) + 64'(span >> 1)) / 64'(span);
            bpm = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
            // floor first, so the ceiling wins when they cross
            if (bpm < {18'd0, floor_x10})
                bpm = {18'd0, floor_x10};
            if (bpm > {18'd0, ceil_x10})
                bpm = {18'd0, ceil_x10};
            res.tempo = bpm[TEMPO_W-1:0];
            res.valid = 1'b1;
        end
        res.held = HELD_W'(held_taps);
        return res;
    endfunction

    always @(posedge i_clk) begin
        tempo_result_t want;
        if (!i_rst_n) begin
            held_taps = 0;
            gap_limit = GAP_TIMEOUT_RST;
            floor_x10 = TEMPO_FLOOR_RST;
            ceil_x10  = TEMPO_CEIL_RST;
            tempo_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAP_TIMEOUT: gap_limit = i_cfg_data;
                    CFG_TEMPO_FLOOR: floor_x10 = i_cfg_data[TEMPO_W-1:0];
                    CFG_TEMPO_CEIL:  ceil_x10  = i_cfg_data[TEMPO_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (tempo_q.size() == 0) begin
                    report_failure($sformatf("unexpected item: tempo %0d valid %0d held %0d",
                                             i_tempo_x10, i_tempo_valid, i_taps_held));
                end else begin
                    want = tempo_q.pop_front();
                    checked_total++;
                    if (i_tempo_x10 !== want.tempo)
                        report_failure($sformatf("tempo_x10 got %0d expected %0d",
                                                 i_tempo_x10, want.tempo));
                    if (i_tempo_valid !== want.valid)
                        report_failure($sformatf("tempo_valid got %0d expected %0d",
                                                 i_tempo_valid, want.valid));
                    if (i_taps_held !== want.held)
                        report_failure($sformatf("taps_held got %0d expected %0d",
                                                 i_taps_held, want.held));
                end
            end
            if (i_in_valid && i_in_ready)
                tempo_q.push_back(take_tap(i_tap_time_ms));
        end
        pending_total = tempo_q.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the tap tempo estimator: clock, reset, tap stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tte_pkg::*;

    localparam int TAPS          = 4;
    localparam int RESULT_LAT    = 40;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int PHASES        = 6;
    localparam int TAPS_PER_SET  = 150;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [31:0]         i_tap_time_ms;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [TEMPO_W-1:0]  o_tempo_x10;
    logic                o_tempo_valid;
    logic [HELD_W-1:0]   o_taps_held;
    logic                i_cfg_we;
    logic [CFG_IW-1:0]   i_cfg_index;
    logic [CFG_DW-1:0]   i_cfg_data;

    int   fail_count;
    int   pending;
    int   checked;
    int   cycle_count = 0;
    int   tap_total = 0;
    int   setting_total = 0;
    int   stall_left = 0;
    logic calm = 1'b0;

    tap_tempo_estimator #(.MAX_TAPS(TAPS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_tap_time_ms(i_tap_time_ms),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_tempo_x10  (o_tempo_x10),
        .o_tempo_valid(o_tempo_valid),
        .o_taps_held  (o_taps_held),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    tte_checker #(.MAX_TAPS(TAPS)) tempo_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_tap_time_ms(i_tap_time_ms),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_tempo_x10  (o_tempo_x10),
        .i_tempo_valid(o_tempo_valid),
        .i_taps_held  (o_taps_held),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side back-pressure: ~30% random stalls plus an occasional long one.
    always @(negedge i_clk) begin
        if (calm) begin
            stall_left = 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(999) < 4) begin
            stall_left = $urandom_range(20, 60);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 30);
        end
    end

    // Presents one tap; returns at the falling edge after it is accepted, valid still high.
    task automatic send_tap(input logic [31:0] stamp);
        int idle;
        idle = (!calm && $urandom_range(99) < 30) ? $urandom_range(1, 6) : 0;
        if (idle > 0) begin
            i_in_valid = 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_tap_time_ms = stamp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tap_total++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (RESULT_LAT) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] timeout, input logic [TEMPO_W-1:0] lo,
                                  input logic [TEMPO_W-1:0] hi);
        wait_idle();
        write_reg(CFG_GAP_TIMEOUT, timeout);
        write_reg(CFG_TEMPO_FLOOR, {2'b00, lo});
        write_reg(CFG_TEMPO_CEIL, {2'b00, hi});
        setting_total++;
    endtask

    // Next tap time: mostly within the timeout so the history fills, with
    // boundary gaps, repeats, backward steps and random jumps mixed in.
    function automatic logic [31:0] next_stamp(input logic [31:0] prev, input logic [15:0] tmo);
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)      return prev + $urandom_range(0, tmo);
        else if (pick < 63) return prev + {16'd0, tmo};
        else if (pick < 70) return prev + {16'd0, tmo} + 32'd1;
        else if (pick < 75) return prev;
        else if (pick < 80) return prev - $urandom_range(1, 1000);
        else if (pick < 85) return $urandom;
        else if (pick < 90) return prev + $urandom_range(1, 20);
        else                return prev + {16'd0, tmo} + $urandom_range(1, 100000);
    endfunction

    initial begin
        logic [31:0]        stamp;
        logic [15:0]        set_tmo;
        logic [TEMPO_W-1:0] set_lo;
        logic [TEMPO_W-1:0] set_hi;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_tap_time_ms = '0;
        i_out_ready   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_GAP_TIMEOUT;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: first tap, zero span, filling and sliding the history,
        // timeout boundary, backward time and counter wrap
        send_tap(32'h0000_0000);
        send_tap(32'h0000_0000);
        send_tap(32'd500);
        send_tap(32'd1000);
        send_tap(32'd1500);
        send_tap(32'd3500);
        send_tap(32'd5501);
        send_tap(32'd5000);
        send_tap(32'hFFFF_FFFF);
        send_tap(32'd499);
        send_tap(32'd999);

        // widest limits: half-way rounding and a tempo below the floor
        apply_settings(16'hFFFF, 14'd10, 14'h3FFF);
        send_tap(32'h8000_0000);
        send_tap(32'h8000_3E80);
        send_tap(32'h8001_3E7F);
        send_tap(32'h8002_3E7E);
        send_tap(32'h8003_3E7D);
        send_tap(32'h8003_4AFD);

        // floor above ceiling
        apply_settings(16'hFFFF, 14'h3FFF, 14'd10);
        send_tap(32'h8003_4B61);

        // zero timeout: only repeated stamps are kept
        apply_settings(16'd0, 14'd10, 14'h3FFF);
        send_tap(32'h1234_5678);
        send_tap(32'h1234_5678);
        send_tap(32'h1234_5679);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    set_tmo = GAP_TIMEOUT_RST; set_lo = TEMPO_FLOOR_RST; set_hi = TEMPO_CEIL_RST;
                end
                1: begin
                    set_tmo = 16'hFFFF; set_lo = 14'd10; set_hi = 14'h3FFF;
                end
                2: begin
                    set_tmo = 16'd1; set_lo = 14'h3FFF; set_hi = 14'd10;
                end
                3: begin
                    set_tmo = 16'd0; set_lo = 14'd10; set_hi = 14'h3FFF;
                end
                default: begin
                    set_tmo = 16'(($urandom_range(1) == 0) ? $urandom_range(250, 4000)
                                                           : $urandom_range(1, 65535));
                    set_lo  = TEMPO_W'($urandom_range(10, 16383));
                    set_hi  = TEMPO_W'($urandom_range(10, 16383));
                end
            endcase
            apply_settings(set_tmo, set_lo, set_hi);
            calm  = (ph == 1);
            stamp = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
            repeat (TAPS_PER_SET) begin
                stamp = next_stamp(stamp, set_tmo);
                send_tap(stamp);
            end
            calm = 1'b0;
        end

        wait_idle();
        $display("%0d taps sent under %0d register settings; %0d tempo results compared",
                 tap_total, setting_total, checked);
        $display("settings ranged over timeouts 0..65535, crossed and widest clamps");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
